// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/bmvm_pkg.sv =====
// Types and constants of the byte memory VM execute unit.
// No dependencies.
package bmvm_pkg;
    // data memory size; addresses wrap by bit select, so it stays a power of two
    localparam int DATA_BYTES = 65536;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_ADD  = 5'd2;
    localparam logic [4:0] OP_SUB  = 5'd3;
    localparam logic [4:0] OP_MUL  = 5'd4;
    localparam logic [4:0] OP_DIV  = 5'd5;
    localparam logic [4:0] OP_SHL  = 5'd6;
    localparam logic [4:0] OP_SHR  = 5'd7;
    localparam logic [4:0] OP_AND  = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_OR   = 5'd10;
    localparam logic [4:0] OP_CMP  = 5'd11;
    localparam logic [4:0] OP_JMP  = 5'd12;
    localparam logic [4:0] OP_JE   = 5'd13;
    localparam logic [4:0] OP_JNE  = 5'd14;
    localparam logic [4:0] OP_JB   = 5'd15;
    localparam logic [4:0] OP_JBE  = 5'd16;
    localparam logic [4:0] OP_JA   = 5'd17;
    localparam logic [4:0] OP_JAE  = 5'd18;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RREG, ST_MEM1, ST_MEM2, ST_MEM3,
        ST_MUL, ST_DIV, ST_EXEC, ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage

// ===== rtl/bmvm_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on bmvm_pkg.
module bmvm_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  bmvm_pkg::div_req_t  req,
    output bmvm_pkg::div_rsp_t  rsp
);
    import bmvm_pkg::*;

    logic [31:0] quo_reg, quo_next, den_reg, den_next;
    logic [32:0] rem_reg, rem_next, trial;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[31]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // divide by zero naturally yields all ones in a restoring divider
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ===== rtl/byte_memory_vm_execute_unit.sv =====
// Byte memory VM execute unit: sequencer, register file and data memory.
// Depends on bmvm_pkg, bmvm_divider and assert_macros.svh.
//
// Usage: drive the item fields and pulse start while busy is low. The item
// is taken at that edge; busy stays high until the result appears. The
// result shows for one cycle with done high; the receiver cannot stall.
// Sequencing: data write and read items go straight to DONE; jumps, halt
// and bad-index items pass RREG then DONE; ALU ops read two registers in
// turn in RREG, then EXEC; MUL adds a state for its registered multiplier;
// DIV waits in DIV for the bit-serial divider. Loads walk the single data
// memory port, one access a cycle, up to two reads plus a write.
// Items are processed one at a time: the register file and data memory
// each have one registered read port and all state updates complete before
// the next item is accepted.
// Reset: after rst_n a clearing pass writes zero to each data memory entry,
// with busy high; the register file is also cleared, one entry a cycle,
// in the same pass.
module byte_memory_vm_execute_unit #(
    parameter int REG_COUNT   = 16,
    parameter int INSTR_BYTES = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [4:0]  opcode,
    input  logic [5:0]  mode_flags,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [15:0] mem_address,
    input  logic [7:0]  mem_byte,
    output logic        done,
    output logic [15:0] next_pc,
    output logic        halted,
    output logic        fault,
    output logic [7:0]  read_byte
);
    import bmvm_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(DATA_BYTES);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [7:0]  dmem [DATA_BYTES];
    logic [31:0] rmem [REG_COUNT];

    state_t state_reg, state_next;
    logic [AW:0]  clr_reg, clr_next;
    logic [1:0]   act_reg;
    logic [4:0]   op_reg;
    logic [5:0]   m_reg;
    logic [31:0]  a_reg, b_reg;
    logic [15:0]  maddr_reg;
    logic [7:0]   mbyte_reg;
    logic [31:0]  x_reg, x_next, v_reg, v_next, prod_reg;
    logic [15:0]  pc_reg, pc_next;
    logic         zf_reg, zf_next, cf_reg, cf_next, hs_reg, hs_next;
    logic         fault_reg, fault_next;
    logic [7:0]   rd_reg, rd_next;
    logic         phase_reg, phase_next;

    logic         d_we, r_we;
    logic [AW-1:0] d_addr;
    logic [7:0]   d_wdata, d_q;
    logic [RW-1:0] r_addr;
    logic [31:0]  r_wdata, r_q;
    div_req_t     dreq;
    div_rsp_t     drsp;

    logic         a_ok, b_ok, accept;
    logic [31:0]  alu;

    bmvm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[d_addr] <= d_wdata;
        d_q <= dmem[d_addr];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
            rmem[r_addr] <= r_wdata;
        r_q <= rmem[r_addr];
    end

    assign a_ok   = (a_reg < 32'(REG_COUNT));
    assign b_ok   = (b_reg < 32'(REG_COUNT));
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu = x_reg + r_q;
            OP_SUB:  alu = x_reg - r_q;
            OP_SHL:  alu = (r_q >= 32'd32) ? '0 : (x_reg << r_q[4:0]);
            OP_SHR:  alu = (r_q >= 32'd32) ? '0 : (x_reg >> r_q[4:0]);
            OP_AND:  alu = x_reg & r_q;
            OP_XOR:  alu = x_reg ^ r_q;
            OP_OR:   alu = x_reg | r_q;
            default: alu = x_reg;
        endcase
    end

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(DATA_BYTES - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    if (action == ACT_EXEC && !hs_reg) state_next = ST_RREG;
                    else state_next = ST_DONE;
                end
            ST_RREG:
                if (op_reg == OP_LOAD)
                begin
                    if (((m_reg[2]) && !b_ok) || (m_reg[0] && !a_ok)) state_next = ST_DONE;
                    else state_next = ST_MEM1;
                end
                else if (op_reg >= OP_ADD && op_reg <= OP_CMP)
                begin
                    if (!a_ok || !b_ok) state_next = ST_DONE;
                    else if (phase_reg) state_next = ST_EXEC;
                end
                else state_next = ST_DONE;
            ST_MEM1: state_next = ST_MEM2;
            ST_MEM2: state_next = ST_MEM3;
            ST_MEM3: state_next = ST_DONE;
            ST_EXEC:
                if (op_reg == OP_MUL) state_next = ST_MUL;
                else if (op_reg == OP_DIV) state_next = ST_DIV;
                else state_next = ST_DONE;
            ST_MUL: state_next = ST_DONE;
            ST_DIV: if (drsp.done) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb
    begin
        clr_next   = clr_reg;
        x_next     = x_reg;
        v_next     = v_reg;
        pc_next    = pc_reg;
        zf_next    = zf_reg;
        cf_next    = cf_reg;
        hs_next    = hs_reg;
        fault_next = fault_reg;
        rd_next    = rd_reg;
        phase_next = phase_reg;
        d_we = 1'b0; d_addr = maddr_reg[AW-1:0]; d_wdata = mbyte_reg;
        r_we = 1'b0; r_addr = b_reg[RW-1:0]; r_wdata = '0;
        dreq.start = 1'b0; dreq.dividend = x_reg; dreq.divisor = r_q;
        case (state_reg)
            ST_CLEAR:
            begin
                d_we = 1'b1; d_addr = clr_reg[AW-1:0]; d_wdata = '0;
                r_we = (clr_reg < (AW+1)'(REG_COUNT));
                r_addr = clr_reg[RW-1:0];
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                fault_next = 1'b0;
                rd_next    = '0;
                phase_next = 1'b0;
                // first read: source reg for load, a-reg for alu
                r_addr = (opcode == OP_LOAD) ? operand_b[RW-1:0] : operand_a[RW-1:0];
                d_addr = mem_address[AW-1:0];
                if (accept && action == ACT_WRITE)
                begin
                    d_we = 1'b1; d_wdata = mem_byte;
                end
                if (accept && action == ACT_EXEC && !hs_reg)
                    pc_next = pc_reg + 16'(INSTR_BYTES);
            end
            ST_RREG:
            begin
                if (op_reg == OP_LOAD)
                begin
                    fault_next = (m_reg[2] && !b_ok) || (m_reg[0] && !a_ok);
                    v_next = m_reg[2] ? r_q : (m_reg[3] ? b_reg : '0);
                    // issue the src indirect byte read, seen on d_q in MEM1
                    d_addr = v_next[AW-1:0];
                    // also fetch dst register for dst indirect
                    r_addr = a_reg[RW-1:0];
                end
                else if (op_reg >= OP_ADD && op_reg <= OP_CMP)
                begin
                    fault_next = !a_ok || !b_ok;
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        r_addr = b_reg[RW-1:0];
                    end
                    // r_q of a arrives now on first phase
                    if (!phase_reg) x_next = r_q;
                end
                else
                begin
                    case (op_reg)
                        OP_HALT: hs_next = 1'b1;
                        OP_JMP:  pc_next = a_reg[15:0];
                        OP_JE:   if (zf_reg) pc_next = a_reg[15:0];
                        OP_JNE:  if (!zf_reg) pc_next = a_reg[15:0];
                        OP_JB:   if (cf_reg) pc_next = a_reg[15:0];
                        OP_JBE:  if (cf_reg || zf_reg) pc_next = a_reg[15:0];
                        OP_JA:   if (!cf_reg) pc_next = a_reg[15:0];
                        OP_JAE:  if (!cf_reg || zf_reg) pc_next = a_reg[15:0];
                        default: pc_next = pc_reg;
                    endcase
                end
            end
            ST_MEM1:
            begin
                // d_q is byte at v (read issued in RREG); r_q is reg[a]
                x_next = r_q;
                if (m_reg[5]) v_next = {24'd0, d_q};
                d_addr = a_reg[AW-1:0];
            end
            ST_MEM2:
            begin
                // d_q is data_mem[a]; choose final store address
                if (m_reg[4])
                    d_addr = m_reg[0] ? x_reg[AW-1:0] : AW'(d_q);
                else
                    d_addr = a_reg[AW-1:0];
                d_wdata = v_reg[7:0];
                // register dst write happens here too
                if (m_reg[4] || !m_reg[0])
                    d_we = m_reg[0] || m_reg[1];
                if (!m_reg[4] && m_reg[0])
                begin
                    r_we = 1'b1; r_addr = a_reg[RW-1:0];
                    r_wdata = v_reg;
                end
            end
            ST_MEM3: ;
            ST_EXEC:
            begin
                r_addr = a_reg[RW-1:0];
                if (op_reg == OP_CMP)
                begin
                    zf_next = (x_reg == r_q);
                    if (x_reg < r_q) cf_next = 1'b1;
                    else if (x_reg > r_q) cf_next = 1'b0;
                end
                else if (op_reg == OP_DIV)
                    dreq.start = 1'b1;
                else if (op_reg != OP_MUL)
                begin
                    r_we = 1'b1; r_wdata = alu;
                end
            end
            ST_MUL:
            begin
                r_we = 1'b1; r_addr = a_reg[RW-1:0]; r_wdata = prod_reg;
            end
            ST_DIV:
            begin
                r_addr = a_reg[RW-1:0];
                if (drsp.done)
                begin
                    r_we = 1'b1; r_wdata = drsp.quotient;
                end
            end
            ST_DONE:
            begin
                if (act_reg == ACT_READ) rd_next = d_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            zf_reg    <= 1'b0;
            cf_reg    <= 1'b0;
            hs_reg    <= 1'b0;
            phase_reg <= 1'b0;
            fault_reg <= 1'b0;
            rd_reg    <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            zf_reg    <= zf_next;
            cf_reg    <= cf_next;
            hs_reg    <= hs_next;
            phase_reg <= phase_next;
            fault_reg <= fault_next;
            rd_reg    <= rd_next;
            done      <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            op_reg    <= opcode;
            m_reg     <= mode_flags;
            a_reg     <= operand_a;
            b_reg     <= operand_b;
            maddr_reg <= mem_address;
            mbyte_reg <= mem_byte;
        end
        x_reg    <= x_next;
        v_reg    <= v_next;
        prod_reg <= x_reg * r_q;
    end

    assign next_pc   = pc_reg;
    assign halted    = hs_reg;
    assign fault     = fault_reg;
    assign read_byte = rd_reg;

    `ASSERT_CLK(a_done_idle, clk, rst_n, done |-> (state_reg == ST_IDLE), "result outside idle")
    `ASSERT_CLK(a_take, clk, rst_n, accept |=> busy, "accepted request did not go busy")
    `ASSERT_CLK(a_halt_hold, clk, rst_n, $past(hs_reg) |-> hs_reg, "halt cleared")
    `ASSERT_RST(a_rst, clk, !rst_n |-> !done, "result during reset")
endmodule
